### src/svc_pkg.sv
// Shared constants, types and character-class functions for the semver string checker.
package svc_pkg;

    localparam int CHAR_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map: index is the word address (paddr[2])
    localparam logic REG_MOD_ENABLE   = 1'b0;
    localparam logic ALLOW_MOD_RESET  = 1'b1;

    localparam logic [3:0] COMPAT_LEN     = 4'd11;
    localparam logic [3:0] NON_COMPAT_LEN = 4'd15;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;

    typedef enum logic [2:0] {
        PH_NUM,
        PH_SUFFIX,
        PH_AFTER_SUFFIX,
        PH_PRE_FIRST,
        PH_PRE_BODY,
        PH_META_FIRST,
        PH_META_BODY
    } t_phase;

    // One processed byte, handed from the parser to the result register
    typedef struct packed {
        logic fire;
        logic is_end;
        logic verdict;
    } t_step;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_part_char(input logic [CHAR_W-1:0] c);
        return is_alnum(c) || (c == CH_DOT) || (c == CH_DASH);
    endfunction

    // Expected byte of the plain or the "non" compatibility suffix at a position
    function automatic logic [CHAR_W-1:0] suffix_char(input logic is_non, input logic [3:0] pos);
        logic [CHAR_W-1:0] ch;
        ch = CH_NUL;
        if (is_non) begin
            case (pos)
                4'd0:    ch = "_";
                4'd1:    ch = "n";
                4'd2:    ch = "o";
                4'd3:    ch = "n";
                4'd4:    ch = "_";
                4'd5:    ch = "c";
                4'd6:    ch = "o";
                4'd7:    ch = "m";
                4'd8:    ch = "p";
                4'd9:    ch = "a";
                4'd10:   ch = "t";
                4'd11:   ch = "i";
                4'd12:   ch = "b";
                4'd13:   ch = "l";
                4'd14:   ch = "e";
                default: ch = CH_NUL;
            endcase
        end else begin
            case (pos)
                4'd0:    ch = "_";
                4'd1:    ch = "c";
                4'd2:    ch = "o";
                4'd3:    ch = "m";
                4'd4:    ch = "p";
                4'd5:    ch = "a";
                4'd6:    ch = "t";
                4'd7:    ch = "i";
                4'd8:    ch = "b";
                4'd9:    ch = "l";
                4'd10:   ch = "e";
                default: ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

endpackage

### src/svc_if.sv
// Valid/ready channel interfaces for input bytes and verdicts.
interface svc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface svc_res_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

### src/svc_apb_regs.sv
// APB configuration register block holding the modifier enable bit.
module svc_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [svc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [svc_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output logic                          o_allow_mod
);
    import svc_pkg::*;

    logic r_allow_mod;
    logic w_sel_allow;

    assign w_sel_allow = (paddr[2] == REG_MOD_ENABLE);
    assign pready      = 1'b1;

    // Write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_mod <= ALLOW_MOD_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_allow) begin
            r_allow_mod <= pwdata[0];
        end
    end

    // Read back
    assign prdata      = w_sel_allow ? {{(APB_DATA_W-1){1'b0}}, r_allow_mod} : '0;
    assign o_allow_mod = r_allow_mod;

endmodule

### src/svc_parser.sv
// Input register and per-byte recognizer state machine.
module svc_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    svc_char_if.sink       i_char_ch,
    input  logic           i_allow_mod,
    input  logic           i_out_free,
    output svc_pkg::t_step o_step
);
    import svc_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_dot_count, n_dot_count;
    logic        r_saw_digit, n_saw_digit;
    logic [3:0]  r_suffix_pos, n_suffix_pos;
    logic        r_suffix_non, n_suffix_non;
    logic        r_failed, n_failed;

    logic        w_fire;
    logic        w_is_end;
    logic        w_verdict;
    logic        w_eff_non;
    logic [3:0]  w_len;

    assign w_is_end = (r_char == CH_NUL);
    // A terminator needs room in the result register; other bytes always move on
    assign w_fire   = r_in_valid && (!w_is_end || i_out_free);
    assign i_char_ch.ready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char_ch.ready) begin
            r_in_valid <= i_char_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char_ch.valid && i_char_ch.ready) begin
            r_char <= i_char_ch.character;
        end
    end

    // Verdict for the string so far
    always_comb begin
        w_verdict = 1'b0;
        if (!r_failed) begin
            case (r_phase)
                PH_NUM:          w_verdict = (r_dot_count == 2'd2) && r_saw_digit;
                PH_AFTER_SUFFIX: w_verdict = 1'b1;
                PH_PRE_BODY:     w_verdict = 1'b1;
                PH_META_BODY:    w_verdict = 1'b1;
                default:         w_verdict = 1'b0;
            endcase
        end
    end

    // Suffix match helpers
    assign w_eff_non = r_suffix_non || ((r_suffix_pos == 4'd1) && (r_char == CH_N));
    assign w_len     = w_eff_non ? NON_COMPAT_LEN : COMPAT_LEN;

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_dot_count  = r_dot_count;
        n_saw_digit  = r_saw_digit;
        n_suffix_pos = r_suffix_pos;
        n_suffix_non = r_suffix_non;
        n_failed     = r_failed;
        if (w_fire) begin
            if (w_is_end) begin
                n_phase      = PH_NUM;
                n_dot_count  = 2'd0;
                n_saw_digit  = 1'b0;
                n_suffix_pos = 4'd0;
                n_suffix_non = 1'b0;
                n_failed     = 1'b0;
            end else if (!r_failed) begin
                case (r_phase)
                    PH_NUM: begin
                        if (is_digit(r_char)) begin
                            n_saw_digit = 1'b1;
                        end else if (r_char == CH_DOT) begin
                            if (!r_saw_digit || (r_dot_count == 2'd2)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_dot_count = r_dot_count + 2'd1;
                                n_saw_digit = 1'b0;
                            end
                        end else if ((r_dot_count != 2'd2) || !r_saw_digit || !i_allow_mod) begin
                            n_failed = 1'b1;
                        end else if (r_char == CH_UNDER) begin
                            n_phase      = PH_SUFFIX;
                            n_suffix_pos = 4'd1;
                            n_suffix_non = 1'b0;
                        end else if (r_char == CH_DASH) begin
                            n_phase = PH_PRE_FIRST;
                        end else if (r_char == CH_PLUS) begin
                            n_phase = PH_META_FIRST;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_SUFFIX: begin
                        n_suffix_non = w_eff_non;
                        if ((r_suffix_pos >= w_len)
                                || (r_char != suffix_char(w_eff_non, r_suffix_pos))) begin
                            n_failed = 1'b1;
                        end else begin
                            n_suffix_pos = r_suffix_pos + 4'd1;
                            if ((r_suffix_pos + 4'd1) == w_len) begin
                                n_phase = PH_AFTER_SUFFIX;
                            end
                        end
                    end
                    PH_AFTER_SUFFIX: begin
                        if (r_char == CH_DASH) begin
                            n_phase = PH_PRE_FIRST;
                        end else if (r_char == CH_PLUS) begin
                            n_phase = PH_META_FIRST;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_PRE_FIRST: begin
                        if (is_alnum(r_char)) n_phase = PH_PRE_BODY;
                        else n_failed = 1'b1;
                    end
                    PH_PRE_BODY: begin
                        if (r_char == CH_PLUS) n_phase = PH_META_FIRST;
                        else if (!is_part_char(r_char)) n_failed = 1'b1;
                    end
                    PH_META_FIRST: begin
                        if (is_alnum(r_char)) n_phase = PH_META_BODY;
                        else n_failed = 1'b1;
                    end
                    PH_META_BODY: begin
                        if (!is_part_char(r_char)) n_failed = 1'b1;
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NUM;
            r_dot_count  <= 2'd0;
            r_saw_digit  <= 1'b0;
            r_suffix_pos <= 4'd0;
            r_suffix_non <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_dot_count  <= n_dot_count;
            r_saw_digit  <= n_saw_digit;
            r_suffix_pos <= n_suffix_pos;
            r_suffix_non <= n_suffix_non;
            r_failed     <= n_failed;
        end
    end

    assign o_step.fire    = w_fire;
    assign o_step.is_end  = w_is_end;
    assign o_step.verdict = w_verdict;

endmodule

### src/svc_out_reg.sv
// Result register that holds a verdict until the receiver takes it.
module svc_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  svc_pkg::t_step i_step,
    svc_res_if.source      o_res_ch,
    output logic           o_free
);
    import svc_pkg::*;

    logic r_valid;
    logic r_res;

    assign o_free = !r_valid || o_res_ch.ready;

    // Load on a terminator, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step.fire && i_step.is_end) begin
            r_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.fire && i_step.is_end) begin
            r_res <= i_step.verdict;
        end
    end

    assign o_res_ch.valid     = r_valid;
    assign o_res_ch.valid_res = r_res;

endmodule

### src/semver_string_checker.sv
// Top level of the semantic version string checker.
// Usage:
//   Feed the version string one byte per transfer on i_char_ch (valid/ready).
//   A zero byte ends the string; exactly one verdict then leaves on o_res_ch,
//   valid_res = 1 for a well-formed MAJOR.MINOR.PATCH[_suffix][-pre][+meta].
//   Other bytes give no result. The APB register at address 0, bit 0, is
//   the modifier enable (reset 1); write it only while the checker is idle.
// Path: a terminator taken on i_char_ch waits in the input register, then
//   loads the result register once it is free; its verdict then transfers
//   on o_res_ch from the result register.
// Throughput: one byte per cycle while no terminator waits on a pending
//   verdict; the recognizer state loop on the registered byte sets the rate.
// Reset: i_rst_n is synchronous, active low; it clears the string state,
//   empties both registers and sets the modifier enable to 1.
// Stall: while a verdict waits on o_res_ch, non-terminator bytes keep
//   flowing; the next terminator waits in the input register until the
//   pending verdict is transferred, and input ready drops behind it.
module semver_string_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    svc_char_if.sink                      i_char_ch,
    svc_res_if.source                     o_res_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [svc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [svc_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import svc_pkg::*;

    logic  w_allow_mod;
    logic  w_out_free;
    t_step w_step;

    // Configuration
    svc_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_allow_mod (w_allow_mod)
    );

    // Recognizer
    svc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_ch   (i_char_ch),
        .i_allow_mod (w_allow_mod),
        .i_out_free  (w_out_free),
        .o_step      (w_step)
    );

    // Result register
    svc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_res_ch (o_res_ch),
        .o_free   (w_out_free)
    );

`ifndef SYNTH
    // A processed terminator always shows a verdict on the next cycle
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step.fire && w_step.is_end) |=> o_res_ch.valid)
        else $error("terminator processed without a verdict");

    // A terminator never overwrites a verdict that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step.fire && w_step.is_end) |-> (!o_res_ch.valid || o_res_ch.ready))
        else $error("pending verdict overwritten");

    // No verdict right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_ch.valid)
        else $error("verdict present after reset");
`endif

endmodule
